// ===== hdl/bfea_pkg.sv =====
`timescale 1ns / 1ps
package bfea_pkg;

   localparam int MAX_EXTENTS = 16;
   localparam int IDX_W       = 16;
   localparam int POS_W       = $clog2(MAX_EXTENTS);
   localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_INIT  = 2'd2;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_ZERO      = 3'd1;
   localparam logic [2:0] STAT_BEYOND    = 3'd2;
   localparam logic [2:0] STAT_OVERLAP   = 3'd3;
   localparam logic [2:0] STAT_TOO_LARGE = 3'd4;
   localparam logic [2:0] STAT_NO_FIT    = 3'd5;
   localparam logic [2:0] STAT_FULL      = 3'd6;

   localparam logic CSR_TABLE_SIZE  = 1'b0;
   localparam logic CSR_MAX_REQUEST = 1'b1;

   localparam logic [IDX_W-1:0] RESET_TABLE_SIZE  = 16'd4096;
   localparam logic [IDX_W-1:0] RESET_MAX_REQUEST = 16'hFFFF;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [IDX_W-1:0] start_index;
      logic [IDX_W-1:0] count;
   } req_item_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [IDX_W-1:0] alloc_index;
      logic [IDX_W-1:0] used_mark;
   } rsp_item_type;

   typedef struct packed {
      logic [IDX_W-1:0] start;
      logic [IDX_W-1:0] length;
   } ext_type;

   typedef struct packed {
      logic past;
      logic end_hit;
      logic overlap;
      logic next_hit;
   } flag_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] length;
      logic [IDX_W-1:0] start;
      logic [POS_W-1:0] idx;
   } tok_type;

   typedef struct packed {
      logic             apply;
      logic             shl;
      logic             shr;
      logic             set;
      logic [CNT_W-1:0] pos;
      logic [POS_W-1:0] set_idx;
      ext_type          set_ext;
   } cmd_type;

endpackage

// ===== hdl/bfea_cell.sv =====
`timescale 1ns / 1ps
module bfea_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bfea_pkg::POS_W-1:0]    cell_idx,
   input  logic                          ext_valid,
   input  logic [bfea_pkg::IDX_W-1:0]    req_start,
   input  logic [bfea_pkg::IDX_W-1:0]    req_count,
   input  bfea_pkg::ext_type             left_ext,
   input  bfea_pkg::ext_type             right_ext,
   input  bfea_pkg::tok_type             tok_in,
   input  bfea_pkg::cmd_type             cmd,
   output bfea_pkg::ext_type             ext,
   output bfea_pkg::flag_type            flags,
   output bfea_pkg::tok_type             tok_out
);

   bfea_pkg::ext_type  ext_ff, ext_in;
   bfea_pkg::flag_type flag_ff, flag_in;
   bfea_pkg::tok_type  tok_ff, tok_in_n;
   logic [bfea_pkg::IDX_W:0] ext_end;
   logic [bfea_pkg::IDX_W:0] req_end;
   logic [bfea_pkg::CNT_W-1:0] idx_w;

   assign ext_end = {1'b0, ext_ff.start} + {1'b0, ext_ff.length};
   assign req_end = {1'b0, req_start} + {1'b0, req_count};
   assign idx_w   = bfea_pkg::CNT_W'(cell_idx);

   always_comb begin
      flag_in.past     = ext_valid && (ext_end > {1'b0, req_start});
      flag_in.end_hit  = (ext_end == {1'b0, req_start});
      flag_in.overlap  = (req_end > {1'b0, ext_ff.start});
      flag_in.next_hit = (req_end == {1'b0, ext_ff.start});
   end

   always_comb begin
      tok_in_n = tok_in;
      if (ext_valid && (ext_ff.length >= req_count) &&
          (!tok_in.found || (ext_ff.length < tok_in.length))) begin
         tok_in_n.found  = 1'b1;
         tok_in_n.length = ext_ff.length;
         tok_in_n.start  = ext_ff.start;
         tok_in_n.idx    = cell_idx;
      end
   end

   always_comb begin
      ext_in = ext_ff;
      if (cmd.apply) begin
         if (cmd.set && (cmd.set_idx == cell_idx)) begin
            ext_in = cmd.set_ext;
         end else if (cmd.shl && (idx_w >= cmd.pos)) begin
            ext_in = right_ext;
         end else if (cmd.shr && (idx_w > cmd.pos)) begin
            ext_in = left_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff.start  <= '0;
         ext_ff.length <= bfea_pkg::RESET_TABLE_SIZE;
      end else begin
         ext_ff <= ext_in;
      end
   end

   always_ff @(posedge clock) begin
      flag_ff <= flag_in;
      tok_ff  <= tok_in_n;
   end

   assign ext     = ext_ff;
   assign flags   = flag_ff;
   assign tok_out = tok_ff;

endmodule

// ===== hdl/best_fit_extent_allocator.sv =====
`timescale 1ns / 1ps
// Best-fit allocator over a sorted list of free extents, one extent per cell.
// Request channel req_*: allocate, free a range or re-initialize the table.
// Each accepted item yields exactly one result item on rsp_* with a status,
// the granted start (allocations) and the used high mark after the request.
// After acceptance the best-fit token walks the cell chain one cell a cycle,
// then the DECIDE state registers the decision and the APPLY state updates
// the cells and registers the result.
// One item is worked on at a time; req_stall is low only when idle, and
// the next item may be taken while a result still waits on rsp_stall.
// The update of a following item waits until the pending result is taken.
// csr_* writes table_size (index 0, used on the next init) and max_request
// (index 1); write only while idle.
// Reset (synchronous): one free extent covering elements 0..4095, used mark
// 0, table_size 4096, max_request 65535, no result pending.
module best_fit_extent_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bfea_pkg::req_item_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bfea_pkg::rsp_item_type         rsp_data,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [bfea_pkg::IDX_W-1:0]     csr_wdata
);

   localparam int N  = bfea_pkg::MAX_EXTENTS;
   localparam int IW = bfea_pkg::IDX_W;
   localparam int PW = bfea_pkg::POS_W;
   localparam int CW = bfea_pkg::CNT_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EVAL   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;
   localparam logic [1:0] S_APPLY  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [PW-1:0] scan_ff, scan_in;
   bfea_pkg::req_item_type req_ff;
   logic [IW-1:0] table_size_ff, max_request_ff, active_ff, used_ff;
   logic [CW-1:0] count_ff;
   logic          rsp_valid_ff;
   bfea_pkg::rsp_item_type rsp_ff;

   bfea_pkg::cmd_type cmd_ff, cmd_in, cmd_live;
   logic [2:0]    dstat_ff, dstat_in;
   logic [IW-1:0] dgrant_ff, dgrant_in, dused_ff, dused_in, dact_ff, dact_in;
   logic [CW-1:0] dcnt_ff, dcnt_in;

   bfea_pkg::ext_type  ext_q [N];
   bfea_pkg::flag_type flag_q[N];
   bfea_pkg::tok_type  tok_q [N];
   bfea_pkg::tok_type  tok_zero;
   logic [N-1:0] valid_v;
   logic out_free, do_apply;

   assign tok_zero = '0;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign do_apply = (state_ff == S_APPLY) && out_free;

   always_comb begin
      cmd_live       = cmd_ff;
      cmd_live.apply = do_apply;
   end

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_cell
         bfea_pkg::ext_type lft, rgt;
         bfea_pkg::tok_type tin;
         assign valid_v[gi] = (CW'(gi) < count_ff);
         if (gi == 0) begin : g_first
            assign lft = ext_q[gi];
            assign tin = tok_zero;
         end else begin : g_mid
            assign lft = ext_q[gi-1];
            assign tin = tok_q[gi-1];
         end
         if (gi == N - 1) begin : g_last
            assign rgt = ext_q[gi];
         end else begin : g_next
            assign rgt = ext_q[gi+1];
         end
         bfea_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cell_idx  (PW'(gi)),
            .ext_valid (valid_v[gi]),
            .req_start (req_ff.start_index),
            .req_count (req_ff.count),
            .left_ext  (lft),
            .right_ext (rgt),
            .tok_in    (tin),
            .cmd       (cmd_live),
            .ext       (ext_q[gi]),
            .flags     (flag_q[gi]),
            .tok_out   (tok_q[gi])
         );
      end
   endgenerate

   logic [N-1:0] g_v, at_pos, before_v;
   logic [CW-1:0] pos, pos_m1;
   logic          ov, jn, jb;
   logic [IW-1:0] next_len, back_start, back_len;
   logic [IW:0]   req_end;
   bfea_pkg::tok_type best;
   logic [IW:0]   alloc_end;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         g_v[i] = !valid_v[i] || flag_q[i].past;
      end
      for (int i = 0; i < N; i++) begin
         at_pos[i]   = g_v[i] && ((i == 0) ? 1'b1 : !g_v[(i == 0) ? 0 : i-1]);
         before_v[i] = !g_v[i] && ((i == N-1) ? 1'b1 : g_v[(i == N-1) ? i : i+1]);
      end
      ov = 1'b0;
      jn = 1'b0;
      jb = 1'b0;
      next_len   = '0;
      back_start = '0;
      back_len   = '0;
      for (int i = 0; i < N; i++) begin
         if (at_pos[i] && valid_v[i]) begin
            ov       = ov | flag_q[i].overlap;
            jn       = jn | flag_q[i].next_hit;
            next_len = next_len | ext_q[i].length;
         end
         if (before_v[i]) begin
            jb         = jb | flag_q[i].end_hit;
            back_start = back_start | ext_q[i].start;
            back_len   = back_len | ext_q[i].length;
         end
      end
      pos    = CW'($countones(~g_v));
      pos_m1 = pos - CW'(1);
   end

   assign req_end   = {1'b0, req_ff.start_index} + {1'b0, req_ff.count};
   assign best      = tok_q[N-1];
   assign alloc_end = {1'b0, best.start} + {1'b0, req_ff.count};

   always_comb begin
      cmd_in    = '0;
      dstat_in  = bfea_pkg::STAT_OK;
      dgrant_in = '0;
      dused_in  = used_ff;
      dcnt_in   = count_ff;
      dact_in   = active_ff;
      case (req_ff.req_type)
         bfea_pkg::REQ_ALLOC: begin
            if (req_ff.count == '0) begin
               dstat_in = bfea_pkg::STAT_ZERO;
            end else if (req_ff.count > max_request_ff) begin
               dstat_in = bfea_pkg::STAT_TOO_LARGE;
            end else if (!best.found) begin
               dstat_in = bfea_pkg::STAT_NO_FIT;
            end else begin
               dgrant_in = best.start;
               if (best.length == req_ff.count) begin
                  cmd_in.shl = 1'b1;
                  cmd_in.pos = CW'(best.idx);
                  dcnt_in    = count_ff - CW'(1);
               end else begin
                  cmd_in.set            = 1'b1;
                  cmd_in.set_idx        = best.idx;
                  cmd_in.set_ext.start  = alloc_end[IW-1:0];
                  cmd_in.set_ext.length = best.length - req_ff.count;
               end
               if (alloc_end > {1'b0, used_ff}) begin
                  dused_in = alloc_end[IW-1:0];
               end
            end
         end
         bfea_pkg::REQ_FREE: begin
            if (req_ff.count == '0) begin
               dstat_in = bfea_pkg::STAT_ZERO;
            end else if (req_end > {1'b0, active_ff}) begin
               dstat_in = bfea_pkg::STAT_BEYOND;
            end else if (ov) begin
               dstat_in = bfea_pkg::STAT_OVERLAP;
            end else if (!jb && !jn && (count_ff >= CW'(N))) begin
               dstat_in = bfea_pkg::STAT_FULL;
            end else begin
               if (jb && jn) begin
                  cmd_in.shl            = 1'b1;
                  cmd_in.pos            = pos;
                  cmd_in.set            = 1'b1;
                  cmd_in.set_idx        = pos_m1[PW-1:0];
                  cmd_in.set_ext.start  = back_start;
                  cmd_in.set_ext.length = back_len + req_ff.count + next_len;
                  dcnt_in               = count_ff - CW'(1);
               end else if (jb) begin
                  cmd_in.set            = 1'b1;
                  cmd_in.set_idx        = pos_m1[PW-1:0];
                  cmd_in.set_ext.start  = back_start;
                  cmd_in.set_ext.length = back_len + req_ff.count;
               end else if (jn) begin
                  cmd_in.set            = 1'b1;
                  cmd_in.set_idx        = pos[PW-1:0];
                  cmd_in.set_ext.start  = req_ff.start_index;
                  cmd_in.set_ext.length = next_len + req_ff.count;
               end else begin
                  cmd_in.shr            = 1'b1;
                  cmd_in.pos            = pos;
                  cmd_in.set            = 1'b1;
                  cmd_in.set_idx        = pos[PW-1:0];
                  cmd_in.set_ext.start  = req_ff.start_index;
                  cmd_in.set_ext.length = req_ff.count;
                  dcnt_in               = count_ff + CW'(1);
               end
               if (req_end == {1'b0, used_ff}) begin
                  dused_in = jb ? back_start : req_ff.start_index;
               end
            end
         end
         bfea_pkg::REQ_INIT: begin
            dact_in  = table_size_ff;
            dused_in = '0;
            if (table_size_ff == '0) begin
               dstat_in = bfea_pkg::STAT_ZERO;
               dcnt_in  = '0;
            end else begin
               cmd_in.set            = 1'b1;
               cmd_in.set_idx        = '0;
               cmd_in.set_ext.start  = '0;
               cmd_in.set_ext.length = table_size_ff;
               dcnt_in               = CW'(1);
            end
         end
         default: begin
            dstat_in = bfea_pkg::STAT_OK;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      unique case (state_ff)
         S_IDLE: begin
            scan_in = '0;
            if (req_valid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            scan_in = scan_ff + PW'(1);
            if (scan_ff == PW'(N - 1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         scan_ff        <= '0;
         table_size_ff  <= bfea_pkg::RESET_TABLE_SIZE;
         max_request_ff <= bfea_pkg::RESET_MAX_REQUEST;
         active_ff      <= bfea_pkg::RESET_TABLE_SIZE;
         used_ff        <= '0;
         count_ff       <= CW'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         if (csr_we) begin
            if (csr_index == bfea_pkg::CSR_TABLE_SIZE) begin
               table_size_ff <= csr_wdata;
            end else begin
               max_request_ff <= csr_wdata;
            end
         end
         if (do_apply) begin
            active_ff    <= dact_ff;
            used_ff      <= dused_ff;
            count_ff     <= dcnt_ff;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && req_valid) begin
         req_ff <= req_data;
      end
      if (state_ff == S_DECIDE) begin
         cmd_ff    <= cmd_in;
         dstat_ff  <= dstat_in;
         dgrant_ff <= dgrant_in;
         dused_ff  <= dused_in;
         dcnt_ff   <= dcnt_in;
         dact_ff   <= dact_in;
      end
      if (do_apply) begin
         rsp_ff.status      <= dstat_ff;
         rsp_ff.alloc_index <= dgrant_ff;
         rsp_ff.used_mark   <= dused_ff;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== verif/best_fit_extent_allocator_test.sv =====
`timescale 1ns / 1ps
module best_fit_extent_allocator_test;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bfea_pkg::req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bfea_pkg::rsp_item_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [bfea_pkg::IDX_W-1:0] csr_wdata = '0;
   logic req_taken = 1'b0;

   best_fit_extent_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bfea_pkg::req_item_type pending_reqs[$];
   bfea_pkg::rsp_item_type expected_rsps[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // predictor state
   int unsigned fx_start[bfea_pkg::MAX_EXTENTS];
   int unsigned fx_len[bfea_pkg::MAX_EXTENTS];
   int unsigned fx_count;
   int unsigned mark_high;
   int unsigned cfg_table;
   int unsigned cfg_maxreq;
   int unsigned active_sz;

   initial forever #5 clock = ~clock;

   function automatic void remove_extent(int unsigned p);
      for (int unsigned i = p; i + 1 < fx_count; i++) begin
         fx_start[i] = fx_start[i+1];
         fx_len[i] = fx_len[i+1];
      end
      fx_count--;
   endfunction

   function automatic logic [2:0] free_range(int unsigned s, int unsigned c);
      int unsigned n;
      int unsigned p;
      int unsigned m;
      longint unsigned e;
      bit jn;
      bit jb;
      n = fx_count;
      p = 0;
      m = s;
      e = longint'(s) + c;
      if (c == 0) return bfea_pkg::STAT_ZERO;
      if (e > active_sz) return bfea_pkg::STAT_BEYOND;
      while (p < n && longint'(fx_start[p]) + fx_len[p] <= s) p++;
      if (p < n && e > fx_start[p]) return bfea_pkg::STAT_OVERLAP;
      if (p > 0 && longint'(fx_start[p-1]) + fx_len[p-1] > s) return bfea_pkg::STAT_OVERLAP;
      jn = (p < n) && (e == fx_start[p]);
      jb = (p > 0) && (longint'(fx_start[p-1]) + fx_len[p-1] == s);
      if (jb && jn) begin
         fx_len[p-1] += c + fx_len[p];
         m = fx_start[p-1];
         remove_extent(p);
      end else if (jb) begin
         fx_len[p-1] += c;
         m = fx_start[p-1];
      end else if (jn) begin
         fx_start[p] = s;
         fx_len[p] += c;
      end else begin
         if (n >= bfea_pkg::MAX_EXTENTS) return bfea_pkg::STAT_FULL;
         for (int unsigned i = n; i > p; i--) begin
            fx_start[i] = fx_start[i-1];
            fx_len[i] = fx_len[i-1];
         end
         fx_start[p] = s;
         fx_len[p] = c;
         fx_count = n + 1;
      end
      if (e == mark_high) mark_high = m;
      return bfea_pkg::STAT_OK;
   endfunction

   function automatic bfea_pkg::rsp_item_type predict_rsp(bfea_pkg::req_item_type r);
      bfea_pkg::rsp_item_type o;
      int unsigned best;
      int unsigned c;
      bit found;
      o = '0;
      c = r.count;
      best = 0;
      found = 0;
      if (r.req_type == bfea_pkg::REQ_ALLOC) begin
         if (c == 0) o.status = bfea_pkg::STAT_ZERO;
         else if (c > cfg_maxreq) o.status = bfea_pkg::STAT_TOO_LARGE;
         else begin
            for (int unsigned i = 0; i < fx_count; i++) begin
               if (fx_len[i] >= c && (!found || fx_len[i] < fx_len[best])) begin
                  best = i;
                  found = 1;
                  if (fx_len[i] == c) break;
               end
            end
            if (!found) o.status = bfea_pkg::STAT_NO_FIT;
            else begin
               o.alloc_index = fx_start[best];
               if (fx_len[best] == c) remove_extent(best);
               else begin
                  fx_start[best] += c;
                  fx_len[best] -= c;
               end
               if (o.alloc_index + c > mark_high) mark_high = o.alloc_index + c;
               o.status = bfea_pkg::STAT_OK;
            end
         end
      end else if (r.req_type == bfea_pkg::REQ_FREE) begin
         o.status = free_range(r.start_index, c);
      end else if (r.req_type == bfea_pkg::REQ_INIT) begin
         fx_count = 0;
         mark_high = 0;
         active_sz = cfg_table;
         o.status = free_range(0, active_sz);
      end
      o.used_mark = mark_high;
      return o;
   endfunction

   // record accepted items
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_rsps.push_back(predict_rsp(req_data));
      end
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected item %h", $time, rsp_data);
            errors++;
         end else if (rsp_data !== expected_rsps[0]) begin
            $display("%0t: expected %h actual %h", $time, expected_rsps[0], rsp_data);
            errors++;
            void'(expected_rsps.pop_front());
         end else begin
            void'(expected_rsps.pop_front());
         end
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int unsigned val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[bfea_pkg::IDX_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == bfea_pkg::CSR_TABLE_SIZE) cfg_table = val;
      else cfg_maxreq = val;
   endtask

   task automatic push_req(logic [1:0] t, int unsigned s, int unsigned c);
      bfea_pkg::req_item_type r;
      r.req_type = t;
      r.start_index = s[bfea_pkg::IDX_W-1:0];
      r.count = c[bfea_pkg::IDX_W-1:0];
      pending_reqs.push_back(r);
   endtask

   task automatic random_phase(int n, int unsigned tsize);
      int k;
      int unsigned t;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         t = $urandom_range(1);
         if (k < 2) push_req(bfea_pkg::REQ_INIT, $urandom, $urandom);
         else if (k < 4) push_req(REQ_UNUSED, $urandom, $urandom);
         else if (k < 8) push_req(t[1:0], $urandom, $urandom);
         else if (k < 50) push_req(bfea_pkg::REQ_ALLOC, $urandom,
                                   $urandom_range(1, tsize / 8 + 1));
         else push_req(bfea_pkg::REQ_FREE, $urandom_range(tsize),
                       $urandom_range(1, tsize / 8 + 1));
      end
   endtask

   initial begin
      fx_start[0] = 0;
      fx_len[0] = 4096;
      fx_count = 1;
      mark_high = 0;
      cfg_table = 4096;
      cfg_maxreq = 65535;
      active_sz = 4096;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_req(bfea_pkg::REQ_ALLOC, 0, 0);
      push_req(bfea_pkg::REQ_FREE, 5, 0);
      push_req(bfea_pkg::REQ_ALLOC, 0, 100);
      push_req(bfea_pkg::REQ_ALLOC, 0, 4096);
      push_req(bfea_pkg::REQ_ALLOC, 0, 65535);
      push_req(bfea_pkg::REQ_FREE, 4000, 200);
      push_req(bfea_pkg::REQ_FREE, 90, 5);
      push_req(bfea_pkg::REQ_FREE, 0, 100);
      push_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
      push_req(bfea_pkg::REQ_INIT, 0, 0);
      for (int i = 0; i < 8; i++) push_req(bfea_pkg::REQ_ALLOC, 0, 2);
      for (int i = 0; i < 8; i++) push_req(bfea_pkg::REQ_FREE, i * 2, 1);
      drain();

      write_csr(bfea_pkg::CSR_MAX_REQUEST, 10);
      write_csr(bfea_pkg::CSR_TABLE_SIZE, 0);
      push_req(bfea_pkg::REQ_INIT, 0, 0);
      push_req(bfea_pkg::REQ_ALLOC, 0, 11);
      push_req(bfea_pkg::REQ_ALLOC, 0, 1);
      push_req(bfea_pkg::REQ_FREE, 0, 1);
      drain();
      write_csr(bfea_pkg::CSR_TABLE_SIZE, 65535);
      write_csr(bfea_pkg::CSR_MAX_REQUEST, 65535);
      push_req(bfea_pkg::REQ_INIT, 0, 0);
      push_req(bfea_pkg::REQ_ALLOC, 0, 65535);
      push_req(bfea_pkg::REQ_FREE, 65534, 1);
      push_req(bfea_pkg::REQ_FREE, 16'hFFFF, 16'hFFFF);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 20 : 57) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 20 : 57) : 0;
         write_csr(bfea_pkg::CSR_TABLE_SIZE, (ph == 0) ? 1 : $urandom_range(16, 512));
         write_csr(bfea_pkg::CSR_MAX_REQUEST, $urandom_range(1, 200));
         push_req(bfea_pkg::REQ_INIT, 0, 0);
         random_phase(150, (ph == 0) ? 64 : cfg_table);
         drain();
      end

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
